[rtl/core/fsgs_pkg.sv]
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types and constants for the falling sand grid step block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsgs_pkg;

   localparam int DEF_GRID_WIDTH  = 128;
   localparam int DEF_GRID_HEIGHT = 128;

   localparam int COORD_W = 8;
   localparam int CELL_W  = 8;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_PASS  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_BELOW,
      ST_LEFT,
      ST_RIGHT,
      ST_VACATE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[rtl/core/falling_sand_grid_step.sv]
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Grid of 8-bit cell types with cell write, cell read and one gravity pass.
// ----------------------------------------------------------------------------
// After reset the block clears all 2^(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) grid
// memory entries (16384 at 128 x 128), one entry a cycle; req_stall stays high
// until then. One item is worked on at a time. A write, a read or an unused
// operation code waits in ST_FINISH while a stalled result holds the output
// register, then loads its result there. A pass sweeps every column left to
// right and rows GRID_HEIGHT-2 up to 0 (nothing on the bottom row can fall). An
// empty cell is passed at once. A filled one reads the cells below, below-left
// and below-right in turn as needed, through the single registered read port,
// and on a move writes its new place, then vacates the old one. A new item can
// be accepted while the last result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module falling_sand_grid_step #(
   parameter int GRID_WIDTH  = fsgs_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = fsgs_pkg::DEF_GRID_HEIGHT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [fsgs_pkg::OP_W-1:0]     req_operation,
   input  wire logic [fsgs_pkg::COORD_W-1:0]  req_x_coord,
   input  wire logic [fsgs_pkg::COORD_W-1:0]  req_y_coord,
   input  wire logic [fsgs_pkg::CELL_W-1:0]   req_cell_type,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [fsgs_pkg::CELL_W-1:0]   rsp_read_type,
   output      logic                          rsp_out_of_range
);

   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int CW    = fsgs_pkg::COORD_W + 1;

   localparam logic [XW-1:0] X_LAST  = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0] Y_START = YW'(GRID_HEIGHT - 2);
   localparam logic [XW-1:0] X_ONE   = XW'(1);
   localparam logic [YW-1:0] Y_ONE   = YW'(1);
   localparam logic [AW-1:0] A_LAST  = {AW{1'b1}};

   logic [fsgs_pkg::CELL_W-1:0] cell_mem [DEPTH];
   logic [fsgs_pkg::CELL_W-1:0] mem_rd_ff;

   fsgs_pkg::state_type state_ff, state_in;
   logic [XW-1:0]       x_ff, x_in;
   logic [YW-1:0]       y_ff, y_in;
   logic [fsgs_pkg::CELL_W-1:0] cell_ff, cell_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                res_read_ff, res_read_in;
   logic                res_oor_ff, res_oor_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [fsgs_pkg::CELL_W-1:0] rsp_read_type_ff, rsp_read_type_in;
   logic                rsp_oor_ff, rsp_oor_in;

   logic                mem_we, mem_re;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [fsgs_pkg::CELL_W-1:0] wr_data;

   logic                in_ok, take_next, last_row, pass_done, has_left, has_right;
   logic [XW-1:0]       req_x, x_left, x_right, nx_x;
   logic [YW-1:0]       req_y, y_below, nx_y;

   assign in_ok = ({1'b0, req_x_coord} < CW'(GRID_WIDTH))
               && ({1'b0, req_y_coord} < CW'(GRID_HEIGHT));
   assign req_x = req_x_coord[XW-1:0];
   assign req_y = req_y_coord[YW-1:0];

   assign x_left    = x_ff - X_ONE;
   assign x_right   = x_ff + X_ONE;
   assign y_below   = y_ff + Y_ONE;
   assign has_left  = (x_ff != '0);
   assign has_right = (x_ff != X_LAST);
   assign last_row  = (y_ff == '0);
   assign pass_done = last_row && !has_right;
   assign nx_x      = last_row ? x_right : x_ff;
   assign nx_y      = last_row ? Y_START : (y_ff - Y_ONE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         mem_rd_ff <= cell_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsgs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff             <= x_in;
      y_ff             <= y_in;
      cell_ff          <= cell_in;
      res_read_ff      <= res_read_in;
      res_oor_ff       <= res_oor_in;
      rsp_read_type_ff <= rsp_read_type_in;
      rsp_oor_ff       <= rsp_oor_in;
   end

   always_comb begin
      state_in         = state_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      cell_in          = cell_ff;
      clr_in           = clr_ff;
      res_read_in      = res_read_ff;
      res_oor_in       = res_oor_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_read_type_in = rsp_read_type_ff;
      rsp_oor_in       = rsp_oor_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      wr_addr          = {x_ff, y_ff};
      rd_addr          = {x_ff, y_ff};
      wr_data          = '0;
      take_next        = 1'b0;
      req_stall        = 1'b1;

      case (state_ff)
         fsgs_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == A_LAST) begin
               state_in = fsgs_pkg::ST_IDLE;
            end
         end
         fsgs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               res_read_in = 1'b0;
               res_oor_in  = 1'b0;
               state_in    = fsgs_pkg::ST_FINISH;
               case (req_operation)
                  fsgs_pkg::OP_WRITE: begin
                     res_oor_in = !in_ok;
                     mem_we     = in_ok;
                     wr_addr    = {req_x, req_y};
                     wr_data    = req_cell_type;
                  end
                  fsgs_pkg::OP_READ: begin
                     res_oor_in  = !in_ok;
                     res_read_in = in_ok;
                     mem_re      = in_ok;
                     rd_addr     = {req_x, req_y};
                  end
                  fsgs_pkg::OP_PASS: begin
                     x_in     = '0;
                     y_in     = Y_START;
                     mem_re   = 1'b1;
                     rd_addr  = {{XW{1'b0}}, Y_START};
                     state_in = fsgs_pkg::ST_CELL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         fsgs_pkg::ST_CELL: begin
            if (mem_rd_ff != '0) begin
               cell_in  = mem_rd_ff;
               mem_re   = 1'b1;
               rd_addr  = {x_ff, y_below};
               state_in = fsgs_pkg::ST_BELOW;
            end else begin
               take_next = 1'b1;
            end
         end
         fsgs_pkg::ST_BELOW: begin
            if (mem_rd_ff == '0) begin
               mem_we   = 1'b1;
               wr_addr  = {x_ff, y_below};
               wr_data  = cell_ff;
               state_in = fsgs_pkg::ST_VACATE;
            end else if (has_left) begin
               mem_re   = 1'b1;
               rd_addr  = {x_left, y_below};
               state_in = fsgs_pkg::ST_LEFT;
            end else if (has_right) begin
               mem_re   = 1'b1;
               rd_addr  = {x_right, y_below};
               state_in = fsgs_pkg::ST_RIGHT;
            end else begin
               take_next = 1'b1;
            end
         end
         fsgs_pkg::ST_LEFT: begin
            if (mem_rd_ff == '0) begin
               mem_we   = 1'b1;
               wr_addr  = {x_left, y_below};
               wr_data  = cell_ff;
               state_in = fsgs_pkg::ST_VACATE;
            end else if (has_right) begin
               mem_re   = 1'b1;
               rd_addr  = {x_right, y_below};
               state_in = fsgs_pkg::ST_RIGHT;
            end else begin
               take_next = 1'b1;
            end
         end
         fsgs_pkg::ST_RIGHT: begin
            if (mem_rd_ff == '0) begin
               mem_we   = 1'b1;
               wr_addr  = {x_right, y_below};
               wr_data  = cell_ff;
               state_in = fsgs_pkg::ST_VACATE;
            end else begin
               take_next = 1'b1;
            end
         end
         fsgs_pkg::ST_VACATE: begin
            mem_we    = 1'b1;
            wr_addr   = {x_ff, y_ff};
            take_next = 1'b1;
         end
         fsgs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_read_type_in = res_read_ff ? mem_rd_ff : '0;
               rsp_oor_in       = res_oor_ff;
               state_in         = fsgs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsgs_pkg::ST_IDLE;
         end
      endcase

      // next cell of the sweep; the read never hits the cell being vacated
      if (take_next) begin
         if (pass_done) begin
            state_in = fsgs_pkg::ST_FINISH;
         end else begin
            x_in     = nx_x;
            y_in     = nx_y;
            mem_re   = 1'b1;
            rd_addr  = {nx_x, nx_y};
            state_in = fsgs_pkg::ST_CELL;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_type    = rsp_read_type_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

`default_nettype wire

[rtl/core/fsgs_checker.sv]
// ----------------------------------------------------------------------------
// fsgs_checker
// Port-level checks for the falling sand grid step block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fsgs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [fsgs_pkg::OP_W-1:0]     req_operation,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [fsgs_pkg::CELL_W-1:0]   rsp_read_type,
   input wire logic                          rsp_out_of_range
);

   // grid clear runs right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("item taken during grid clear");

   // one item at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // cell access with a free output goes straight through ST_FINISH to a result
   a_access_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid && req_operation != fsgs_pkg::OP_PASS
      |-> ##2 rsp_valid)
      else $error("cell access result late");

   a_oor_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_read_type == '0)
      else $error("data returned on out of range item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_type)
      && $stable(rsp_out_of_range))
      else $error("stalled result changed");

endmodule

bind falling_sand_grid_step fsgs_checker u_fsgs_checker (.*);

`default_nettype wire
